// ----- sv/cwc_pkg.sv -----
// Shared types and constants for the congestion window controller.
`timescale 1ns / 1ps

package cwc_pkg;

    // Mode codes as they appear on the mode output.
    localparam logic [2:0] MODE_RECOVER = 3'd0;
    localparam logic [2:0] MODE_STABLE  = 3'd1;
    localparam logic [2:0] MODE_DRAIN   = 3'd2;
    localparam logic [2:0] MODE_GAIN1   = 3'd3;
    localparam logic [2:0] MODE_GAIN2   = 3'd4;

    // Command codes of an input item.
    localparam logic CMD_ACK  = 1'b0;
    localparam logic CMD_LOSS = 1'b1;

    // Operand selection for the shared divider.
    localparam logic [1:0] DSEL_EST  = 2'd0;
    localparam logic [1:0] DSEL_GROW = 2'd1;
    localparam logic [1:0] DSEL_PAC  = 2'd2;

    // Divider geometry.
    localparam int DVD_W     = 62;
    localparam int DSR_W     = 24;
    localparam int DIV_CNT_W = 6;

    // Window and factor limits.
    localparam logic [31:0] WIN_MIN   = 32'd4;
    localparam logic [31:0] WIN_MAX   = 32'd33554432;
    localparam logic [7:0]  INC_MIN   = 8'd2;
    localparam logic [7:0]  INC_MAX   = 8'd128;
    localparam logic [7:0]  SS_INC    = 8'd2;
    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [23:0] RTT_RESET = 24'd1000000;
    localparam logic [23:0] MIN_RESET = 24'd10000000;
    localparam logic [15:0] SEG_RESET = 16'd1460;
    localparam logic [47:0] PACE_MAX  = 48'hFFFF_FFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       loss;
        logic       est_mul;
        logic       div_start;
        logic [1:0] div_sel;
        logic       upd;
        logic       trans;
        logic       pac_mul1;
        logic       pac_mul2;
        logic       pac_zero;
        logic       pac_set;
        logic       emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_loss;
        logic need_est;
        logic need_grow;
        logic is_gain;
        logic div_busy;
    } t_dp_sts;

endpackage

// ----- sv/cwc_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cwc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cwc_pkg::DVD_W-1:0]  i_dividend,
    input  logic [cwc_pkg::DSR_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [cwc_pkg::DVD_W-1:0]  o_quotient
);

    logic                             r_busy, n_busy;
    logic [cwc_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [cwc_pkg::DSR_W-1:0]        r_rem, n_rem;
    logic [cwc_pkg::DVD_W-1:0]        r_quo, n_quo;
    logic [cwc_pkg::DSR_W-1:0]        r_dsr, n_dsr;
    logic [cwc_pkg::DSR_W:0]          w_part;
    logic [cwc_pkg::DSR_W:0]          w_diff;

    // Bring down the next dividend bit and try a subtraction.
    assign w_part = {r_rem, r_quo[cwc_pkg::DVD_W-1]};
    assign w_diff = w_part - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (w_part >= {1'b0, r_dsr}) begin
                n_rem = w_diff[cwc_pkg::DSR_W-1:0];
                n_quo = {r_quo[cwc_pkg::DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_part[cwc_pkg::DSR_W-1:0];
                n_quo = {r_quo[cwc_pkg::DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == cwc_pkg::DIV_CNT_W'(cwc_pkg::DVD_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    // Control state is reset; operands are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ----- sv/cwc_datapath.sv -----
// Datapath: controller state, arithmetic, shared divider and result register.
`timescale 1ns / 1ps

module cwc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_command,
    input  logic [39:0]       i_event_time,
    input  logic [23:0]       i_rtt_sample,
    input  logic [25:0]       i_packets_in_flight,
    input  cwc_pkg::t_dp_cmd  i_cmd,
    output cwc_pkg::t_dp_sts  o_sts,
    output logic [31:0]       o_window,
    output logic [47:0]       o_pace_bps,
    output logic [2:0]        o_mode,
    output logic              o_slow_start
);

    // Architectural state.
    logic [15:0] r_seg;
    logic [2:0]  r_mode, n_mode;
    logic [39:0] r_tt, n_tt;
    logic [31:0] r_window, n_window;
    logic [31:0] r_thr, n_thr;
    logic [31:0] r_path, n_path;
    logic [31:0] r_prev, n_prev;
    logic [7:0]  r_incf, n_incf;
    logic [23:0] r_last;
    logic [23:0] r_min, n_min;
    logic [47:0] r_pace;

    // Latched item and work registers.
    logic        r_cmd;
    logic [39:0] r_time;
    logic [23:0] r_rtt;
    logic [25:0] r_inflight;
    logic [cwc_pkg::DVD_W-1:0] r_prod;

    // Result register.
    logic [31:0] r_o_window;
    logic [47:0] r_o_pace;
    logic [2:0]  r_o_mode;
    logic        r_o_ss;

    // Divider connection.
    logic [cwc_pkg::DVD_W-1:0] w_dvd;
    logic [cwc_pkg::DSR_W-1:0] w_dsr;
    logic                      w_busy;
    logic [cwc_pkg::DVD_W-1:0] w_quo;

    logic        w_ss;
    logic        w_gain;
    logic [28:0] w_span;
    logic [40:0] w_deadline;
    logic        w_exp;
    logic [7:0]  w_grow_f;
    logic [32:0] w_grow_a;
    logic [32:0] w_grow_b;
    logic [32:0] w_grown;
    logic [31:0] w_est;
    logic [32:0] w_raw;
    logic [8:0]  w_incf2;
    logic        w_react;
    logic [49:0] w_est_prod;
    logic [41:0] w_pac_prod;

    assign w_ss   = r_window < r_thr;
    assign w_gain = (r_mode == cwc_pkg::MODE_GAIN1) || (r_mode == cwc_pkg::MODE_GAIN2);

    // Timeout: the multiple of the last round trip depends on mode and slow start.
    always_comb begin
        if (w_ss) begin
            w_span = {4'd0, r_last, 1'b0};
        end else if (r_mode == cwc_pkg::MODE_RECOVER || r_mode == cwc_pkg::MODE_DRAIN) begin
            w_span = {5'd0, r_last};
        end else if (r_mode == cwc_pkg::MODE_STABLE) begin
            w_span = {r_last, 5'd0};
        end else begin
            w_span = {4'd0, r_last, 1'b0};
        end
    end
    assign w_deadline = {1'b0, r_tt} + {12'd0, w_span};
    assign w_exp      = {1'b0, r_time} > w_deadline;

    // Grown window: base plus base divided by the factor, at least base plus four.
    assign w_grow_f = w_ss ? cwc_pkg::SS_INC : r_incf;
    assign w_grow_a = {1'b0, r_path} + {1'b0, w_quo[31:0]};
    assign w_grow_b = {1'b0, r_path} + {1'b0, cwc_pkg::WIN_MIN};
    assign w_grown  = (w_grow_a > w_grow_b) ? w_grow_a : w_grow_b;

    // Bandwidth ratio, saturated to 32 bits.
    assign w_est = (|w_quo[cwc_pkg::DVD_W-1:32]) ? 32'hFFFF_FFFF : w_quo[31:0];

    // Full-width products for the estimate and the first pacing step.
    assign w_est_prod = r_inflight * r_min;
    assign w_pac_prod = r_window[25:0] * r_seg;

    // Divider operands.
    always_comb begin
        unique case (i_cmd.div_sel)
            cwc_pkg::DSEL_GROW: begin
                w_dvd = {30'd0, r_path};
                w_dsr = {16'd0, w_grow_f};
            end
            cwc_pkg::DSEL_PAC: begin
                w_dvd = r_prod;
                w_dsr = r_last;
            end
            default: begin
                w_dvd = r_prod;
                w_dsr = r_rtt;
            end
        endcase
    end

    cwc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .o_busy     (w_busy),
        .o_quotient (w_quo)
    );

    // Loss reaction.
    assign w_react = (w_gain && (r_incf < cwc_pkg::INC_MAX)) || w_ss;
    assign w_incf2 = {r_incf, 1'b0};

    // Next state for the loss update and the mode transition of an acknowledgement.
    always_comb begin
        n_mode   = r_mode;
        n_tt     = r_tt;
        n_thr    = r_thr;
        n_path   = r_path;
        n_prev   = r_prev;
        n_incf   = r_incf;
        n_min    = r_min;
        n_window = r_window;
        w_raw    = {1'b0, r_window};
        if (i_cmd.loss) begin
            if (w_react) begin
                n_incf   = (w_incf2 > {1'b0, cwc_pkg::INC_MAX}) ? cwc_pkg::INC_MAX
                                                                 : w_incf2[7:0];
                n_mode   = cwc_pkg::MODE_RECOVER;
                n_tt     = r_time;
                n_window = r_path;
                n_thr    = r_path;
            end
        end else begin
            if (w_ss) begin
                if (r_mode == cwc_pkg::MODE_GAIN1) begin
                    if (w_exp) begin
                        n_mode = cwc_pkg::MODE_GAIN2;
                        n_tt   = r_time;
                    end
                end else if (r_mode == cwc_pkg::MODE_GAIN2) begin
                    if (w_exp) begin
                        n_tt = r_time;
                        if (r_path > r_prev) begin
                            n_mode = cwc_pkg::MODE_GAIN1;
                            w_raw  = w_grown;
                            n_prev = r_path;
                        end else begin
                            n_mode = cwc_pkg::MODE_RECOVER;
                            w_raw  = {1'b0, r_path};
                            n_thr  = r_path;
                        end
                    end
                end else begin
                    n_mode = cwc_pkg::MODE_GAIN1;
                    n_tt   = r_time;
                    n_path = cwc_pkg::WIN_MIN;
                    n_prev = '0;
                    w_raw  = {1'b0, cwc_pkg::WIN_MIN};
                    n_min  = r_last;
                end
            end else if (r_mode == cwc_pkg::MODE_RECOVER || r_mode == cwc_pkg::MODE_STABLE) begin
                if (w_exp) begin
                    n_mode = cwc_pkg::MODE_DRAIN;
                    n_tt   = r_time;
                    w_raw  = {1'b0, cwc_pkg::WIN_MIN};
                    n_thr  = cwc_pkg::WIN_MIN;
                end
            end else if (r_mode == cwc_pkg::MODE_DRAIN) begin
                if (w_exp) begin
                    n_mode = cwc_pkg::MODE_GAIN1;
                    n_tt   = r_time;
                    w_raw  = w_grown;
                end
            end else if (r_mode == cwc_pkg::MODE_GAIN1) begin
                if (w_exp) begin
                    n_mode = cwc_pkg::MODE_GAIN2;
                    n_tt   = r_time;
                    n_path = '0;
                end
            end else if (r_mode == cwc_pkg::MODE_GAIN2) begin
                if (w_exp) begin
                    n_mode = cwc_pkg::MODE_STABLE;
                    n_tt   = r_time;
                    w_raw  = {1'b0, r_path};
                    n_thr  = r_path;
                    if (r_incf > cwc_pkg::INC_MIN) begin
                        n_incf = r_incf - 8'd1;
                    end
                    n_min  = r_last;
                end
            end
            // Clamp the window after every acknowledgement.
            if (w_raw < {1'b0, cwc_pkg::WIN_MIN}) begin
                n_window = cwc_pkg::WIN_MIN;
            end else if (w_raw > {1'b0, cwc_pkg::WIN_MAX}) begin
                n_window = cwc_pkg::WIN_MAX;
            end else begin
                n_window = w_raw[31:0];
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg    <= cwc_pkg::SEG_RESET;
            r_mode   <= cwc_pkg::MODE_RECOVER;
            r_tt     <= '0;
            r_window <= cwc_pkg::WIN_MIN;
            r_thr    <= cwc_pkg::WIN_MAX;
            r_path   <= cwc_pkg::WIN_MIN;
            r_prev   <= '0;
            r_incf   <= cwc_pkg::INC_MIN;
            r_last   <= cwc_pkg::RTT_RESET;
            r_min    <= cwc_pkg::MIN_RESET;
            r_pace   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_seg <= i_cfg_data;
            end
            if (i_cmd.loss || i_cmd.trans) begin
                r_mode   <= n_mode;
                r_tt     <= n_tt;
                r_window <= n_window;
                r_thr    <= n_thr;
                r_path   <= n_path;
                r_prev   <= n_prev;
                r_incf   <= n_incf;
                r_min    <= n_min;
            end
            // Sample update ahead of the mode transition.
            if (i_cmd.upd && (r_rtt != '0)) begin
                if (r_mode == cwc_pkg::MODE_GAIN2) begin
                    if (r_path == '0) begin
                        r_path <= w_est;
                    end else if (r_path < w_est) begin
                        if (r_path != 32'hFFFF_FFFF) begin
                            r_path <= r_path + 32'd1;
                        end
                    end else begin
                        r_path <= r_path - 32'd1;
                    end
                end
                r_last <= r_rtt;
                if (r_rtt < r_min) begin
                    r_min <= r_rtt;
                end
            end
            if (i_cmd.pac_zero) begin
                r_pace <= '0;
            end
            if (i_cmd.pac_set) begin
                r_pace <= (|w_quo[cwc_pkg::DVD_W-1:48]) ? cwc_pkg::PACE_MAX : w_quo[47:0];
            end
        end
    end

    // Item latch, products and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_command;
            r_time     <= i_event_time;
            r_rtt      <= i_rtt_sample;
            r_inflight <= i_packets_in_flight;
        end
        if (i_cmd.est_mul) begin
            r_prod <= {12'd0, w_est_prod};
        end else if (i_cmd.pac_mul1) begin
            r_prod <= {20'd0, w_pac_prod};
        end else if (i_cmd.pac_mul2) begin
            r_prod <= r_prod[41:0] * cwc_pkg::US_PER_S;
        end
        if (i_cmd.emit) begin
            r_o_window <= r_window;
            r_o_pace   <= r_pace;
            r_o_mode   <= r_mode;
            r_o_ss     <= w_ss;
        end
    end

    assign o_sts.is_loss   = (r_cmd == cwc_pkg::CMD_LOSS);
    assign o_sts.need_est  = (r_rtt != '0) && (r_mode == cwc_pkg::MODE_GAIN2);
    assign o_sts.need_grow = w_exp
                           && ((w_ss && (r_mode == cwc_pkg::MODE_GAIN2) && (r_path > r_prev))
                               || (!w_ss && (r_mode == cwc_pkg::MODE_DRAIN)));
    assign o_sts.is_gain   = w_gain;
    assign o_sts.div_busy  = w_busy;

    assign o_window     = r_o_window;
    assign o_pace_bps   = r_o_pace;
    assign o_mode       = r_o_mode;
    assign o_slow_start = r_o_ss;

endmodule

// ----- sv/cwc_ctrl.sv -----
// Controller: sequences the datapath through one item and runs the handshakes.
`timescale 1ns / 1ps

module cwc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  cwc_pkg::t_dp_sts  i_sts,
    output cwc_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_START     = 4'd1;
    localparam logic [3:0] S_EST_MUL   = 4'd2;
    localparam logic [3:0] S_EST_DIV   = 4'd3;
    localparam logic [3:0] S_EST_WAIT  = 4'd4;
    localparam logic [3:0] S_UPD       = 4'd5;
    localparam logic [3:0] S_CHECK     = 4'd6;
    localparam logic [3:0] S_GROW_WAIT = 4'd7;
    localparam logic [3:0] S_TRANS     = 4'd8;
    localparam logic [3:0] S_PAC_MUL1  = 4'd9;
    localparam logic [3:0] S_PAC_MUL2  = 4'd10;
    localparam logic [3:0] S_PAC_DIV   = 4'd11;
    localparam logic [3:0] S_PAC_WAIT  = 4'd12;
    localparam logic [3:0] S_PAC_SET   = 4'd13;
    localparam logic [3:0] S_FIN       = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = cwc_pkg::DSEL_EST;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_loss) begin
                    o_cmd.loss = 1'b1;
                    n_state    = S_FIN;
                end else if (i_sts.need_est) begin
                    n_state = S_EST_MUL;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_EST_MUL: begin
                o_cmd.est_mul = 1'b1;
                n_state       = S_EST_DIV;
            end
            S_EST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_EST_WAIT;
            end
            S_EST_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.need_grow) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = cwc_pkg::DSEL_GROW;
                    n_state         = S_GROW_WAIT;
                end else begin
                    n_state = S_TRANS;
                end
            end
            S_GROW_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_TRANS;
                end
            end
            S_TRANS: begin
                o_cmd.trans = 1'b1;
                n_state     = S_PAC_MUL1;
            end
            S_PAC_MUL1: begin
                if (i_sts.is_gain) begin
                    o_cmd.pac_zero = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.pac_mul1 = 1'b1;
                    n_state        = S_PAC_MUL2;
                end
            end
            S_PAC_MUL2: begin
                o_cmd.pac_mul2 = 1'b1;
                n_state        = S_PAC_DIV;
            end
            S_PAC_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = cwc_pkg::DSEL_PAC;
                n_state         = S_PAC_WAIT;
            end
            S_PAC_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_PAC_SET;
                end
            end
            S_PAC_SET: begin
                o_cmd.pac_set = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on emit, cleared when the item is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/congestion_window_controller.sv -----
// Top level of the congestion window controller.
// Sequencing: a loss item has its result registered without a divider pass; an
// acknowledgement makes up to two passes of the 62-step divider.
// Throughput: one item at a time; the next item is accepted once the result is
// registered, while that result may still wait on the output.
// Reset: synchronous, active low; restores the controller state and the segment size to 1460.
`timescale 1ns / 1ps

module congestion_window_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [39:0] i_event_time,
    input  logic [23:0] i_rtt_sample,
    input  logic [25:0] i_packets_in_flight,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_window,
    output logic [47:0] o_pace_bps,
    output logic [2:0]  o_mode,
    output logic        o_slow_start
);

    cwc_pkg::t_dp_cmd w_cmd;
    cwc_pkg::t_dp_sts w_sts;

    cwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cwc_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_command           (i_command),
        .i_event_time        (i_event_time),
        .i_rtt_sample        (i_rtt_sample),
        .i_packets_in_flight (i_packets_in_flight),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .o_window            (o_window),
        .o_pace_bps          (o_pace_bps),
        .o_mode              (o_mode),
        .o_slow_start        (o_slow_start)
    );

endmodule
